/* hdl/bpa_pkg.sv */
`timescale 1ns / 1ps
package bpa_pkg;

  localparam int MAX_ANTENNAS     = 64;
  localparam int WEIGHT_FRAC_BITS = 14;

  localparam int ANT_W     = 7;
  localparam int ANT_RESET = 24;
  localparam int ANT_CLAMP = (MAX_ANTENNAS < (1 << ANT_W) - 1) ? MAX_ANTENNAS
                                                               : (1 << ANT_W) - 1;
  localparam int DEN_W     = 2 * ANT_W;
  localparam int DEN_RESET = ANT_RESET * ANT_RESET;

  localparam int SMP_W  = 8;
  localparam int NIB_W  = 4;
  localparam int WGT_W  = 16;
  localparam int PROD_W = NIB_W + WGT_W + 1;
  localparam int ACC_W  = 26;
  localparam int SQ_W   = 2 * ACC_W;
  localparam int SUM_W  = SQ_W + 1;
  localparam int POW_W  = SUM_W - 2 * WEIGHT_FRAC_BITS;
  localparam int QUO_W  = 8;
  localparam int CMP_W  = (POW_W > DEN_W + QUO_W) ? POW_W : DEN_W + QUO_W;

  localparam int NUM_ACC = 4;
  localparam int CNT_W   = 3;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;
  localparam int Q_CNT_W = Q_AW + 1;

  typedef struct packed {
    logic signed [NIB_W-1:0] xr;
    logic signed [NIB_W-1:0] xi;
    logic signed [NIB_W-1:0] yr;
    logic signed [NIB_W-1:0] yi;
    logic signed [WGT_W-1:0] wrx;
    logic signed [WGT_W-1:0] wix;
    logic signed [WGT_W-1:0] wry;
    logic signed [WGT_W-1:0] wiy;
    logic                    last;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

endpackage

/* hdl/bpa_if.sv */
`timescale 1ns / 1ps
interface bpa_in_if;
  logic                             valid;
  logic                             ready;
  logic [bpa_pkg::SMP_W-1:0]        sample_x;
  logic [bpa_pkg::SMP_W-1:0]        sample_y;
  logic signed [bpa_pkg::WGT_W-1:0] weight_re_x;
  logic signed [bpa_pkg::WGT_W-1:0] weight_im_x;
  logic signed [bpa_pkg::WGT_W-1:0] weight_re_y;
  logic signed [bpa_pkg::WGT_W-1:0] weight_im_y;
  logic                             last_antenna;

  modport source (output valid, sample_x, sample_y, weight_re_x, weight_im_x,
                  weight_re_y, weight_im_y, last_antenna, input ready);
  modport sink (input valid, sample_x, sample_y, weight_re_x, weight_im_x,
                weight_re_y, weight_im_y, last_antenna, output ready);
endinterface

interface bpa_out_if;
  logic                      valid;
  logic                      ready;
  logic [bpa_pkg::QUO_W-1:0] beam_power;
  logic                      power_saturated;

  modport source (output valid, beam_power, power_saturated, input ready);
  modport sink (input valid, beam_power, power_saturated, output ready);
endinterface

interface bpa_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [bpa_pkg::ANT_W-1:0] antennas_used;

  modport source (output valid, antennas_used, input ready);
  modport sink (input valid, antennas_used, output ready);
endinterface

/* hdl/beamformer_power_accumulator_core.sv */
`timescale 1ns / 1ps
// Dual-polarization beamformer power detector. Each request carries one antenna's
// 4+4 bit complex samples for X and Y and its Q2.14 weights; the block accumulates
// the weighted sums and, on the request marked last, returns the beam power
// divided by the square of antennas_used, clamped to 255 with a flag. A 4-entry
// queue takes requests at one per cycle while not full; the back end absorbs one per
// cycle while accumulating. A last request holds the back end as one shared 26x26
// squaring multiplier works over four accumulators, the divider loads, the bit-serial
// divider runs (skipped when the quotient saturates) and the result register loads,
// plus any wait for it to drain. antennas_used is clamped to 1..64 on write into a
// register, whose square is registered again on its way to the divider.
module beamformer_power_accumulator_core (
  input logic       clk,
  input logic       rst_n,
  bpa_in_if.sink    in_ch,
  bpa_cfg_if.sink   cfg_ch,
  bpa_out_if.source out_ch
);

  bpa_pkg::q_head_t            q_head;
  logic                        q_pop;
  logic [bpa_pkg::DEN_W-1:0]   denom;

  bpa_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .q_head (q_head),
    .q_pop  (q_pop),
    .denom  (denom)
  );

  bpa_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_head (q_head),
    .q_pop  (q_pop),
    .denom  (denom),
    .out_ch (out_ch)
  );

endmodule

/* hdl/bpa_front.sv */
`timescale 1ns / 1ps
module bpa_front (
  input  logic                        clk,
  input  logic                        rst_n,
  bpa_in_if.sink                      in_ch,
  bpa_cfg_if.sink                     cfg_ch,
  output bpa_pkg::q_head_t            q_head,
  input  logic                        q_pop,
  output logic [bpa_pkg::DEN_W-1:0]   denom
);

  logic [bpa_pkg::ANT_W-1:0]   n_r;
  logic [bpa_pkg::ANT_W-1:0]   n_nxt;
  logic [bpa_pkg::DEN_W-1:0]   denom_r;

  bpa_pkg::item_t              q_mem_r [bpa_pkg::Q_DEPTH];
  bpa_pkg::item_t              item_in;
  logic [bpa_pkg::Q_AW-1:0]    wr_ptr_r;
  logic [bpa_pkg::Q_AW-1:0]    rd_ptr_r;
  logic [bpa_pkg::Q_CNT_W-1:0] cnt_r;
  logic [bpa_pkg::Q_CNT_W-1:0] cnt_nxt;
  logic                        push;
  logic                        pop;

  // antenna count register, clamped on write
  always_comb begin
    if (cfg_ch.antennas_used == '0) begin
      n_nxt = bpa_pkg::ANT_W'(1);
    end else if (int'(cfg_ch.antennas_used) > bpa_pkg::ANT_CLAMP) begin
      n_nxt = bpa_pkg::ANT_W'(bpa_pkg::ANT_CLAMP);
    end else begin
      n_nxt = cfg_ch.antennas_used;
    end
  end

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r     <= bpa_pkg::ANT_W'(bpa_pkg::ANT_RESET);
      denom_r <= bpa_pkg::DEN_W'(bpa_pkg::DEN_RESET);
    end else begin
      if (cfg_ch.valid) begin
        n_r <= n_nxt;
      end
      denom_r <= bpa_pkg::DEN_W'(n_r) * bpa_pkg::DEN_W'(n_r);
    end
  end

  assign denom = denom_r;

  // split nibbles
  always_comb begin
    item_in.xr   = in_ch.sample_x[bpa_pkg::NIB_W-1:0];
    item_in.xi   = in_ch.sample_x[bpa_pkg::SMP_W-1:bpa_pkg::NIB_W];
    item_in.yr   = in_ch.sample_y[bpa_pkg::NIB_W-1:0];
    item_in.yi   = in_ch.sample_y[bpa_pkg::SMP_W-1:bpa_pkg::NIB_W];
    item_in.wrx  = in_ch.weight_re_x;
    item_in.wix  = in_ch.weight_im_x;
    item_in.wry  = in_ch.weight_re_y;
    item_in.wiy  = in_ch.weight_im_y;
    item_in.last = in_ch.last_antenna;
  end

  assign in_ch.ready = (cnt_r != bpa_pkg::Q_CNT_W'(bpa_pkg::Q_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign pop         = q_pop && (cnt_r != '0);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + bpa_pkg::Q_CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - bpa_pkg::Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + bpa_pkg::Q_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + bpa_pkg::Q_AW'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= item_in;
    end
  end

  assign q_head.valid = (cnt_r != '0);
  assign q_head.item  = q_mem_r[rd_ptr_r];

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= bpa_pkg::Q_CNT_W'(bpa_pkg::Q_DEPTH))
    else $error("queue count beyond depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0 && cnt_r != bpa_pkg::Q_CNT_W'(bpa_pkg::Q_DEPTH)) |->
      (wr_ptr_r != rd_ptr_r))
    else $error("queue pointers disagree with count");

endmodule

/* hdl/bpa_back.sv */
`timescale 1ns / 1ps
module bpa_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  bpa_pkg::q_head_t          q_head,
  output logic                      q_pop,
  input  logic [bpa_pkg::DEN_W-1:0] denom,
  bpa_out_if.source                 out_ch
);

  typedef enum logic [4:0] {
    S_MAC  = 5'b00001,
    S_SQR  = 5'b00010,
    S_LOAD = 5'b00100,
    S_DIV  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  logic signed [bpa_pkg::ACC_W-1:0]  acc_rx_r;
  logic signed [bpa_pkg::ACC_W-1:0]  acc_ix_r;
  logic signed [bpa_pkg::ACC_W-1:0]  acc_ry_r;
  logic signed [bpa_pkg::ACC_W-1:0]  acc_iy_r;
  logic signed [bpa_pkg::PROD_W-1:0] pr_rx;
  logic signed [bpa_pkg::PROD_W-1:0] pr_ix;
  logic signed [bpa_pkg::PROD_W-1:0] pr_ry;
  logic signed [bpa_pkg::PROD_W-1:0] pr_iy;

  logic [bpa_pkg::CNT_W-1:0]         cnt_r;
  logic signed [bpa_pkg::ACC_W-1:0]  sq_sel;
  logic signed [bpa_pkg::SQ_W-1:0]   sq_full;
  logic [bpa_pkg::SQ_W-1:0]          prod_r;
  logic [bpa_pkg::SUM_W-1:0]         sum_r;
  logic [bpa_pkg::POW_W-1:0]         pow;
  logic [bpa_pkg::CMP_W-1:0]         rem_r;
  logic [bpa_pkg::CMP_W-1:0]         trial;
  logic [bpa_pkg::CMP_W-1:0]         sat_lim;
  logic                              ge;
  logic [bpa_pkg::QUO_W-1:0]         quo_r;
  logic                              sat_r;

  logic                              out_valid_r;
  logic [bpa_pkg::QUO_W-1:0]         power_r;
  logic                              sat_out_r;
  logic                              out_load;

  bpa_pkg::item_t                    it;

  assign it    = q_head.item;
  assign q_pop = (state_r == S_MAC) && q_head.valid;

  // complex multiply, one per polarization
  always_comb begin
    pr_rx = bpa_pkg::PROD_W'(it.xr) * bpa_pkg::PROD_W'(it.wrx)
          - bpa_pkg::PROD_W'(it.xi) * bpa_pkg::PROD_W'(it.wix);
    pr_ix = bpa_pkg::PROD_W'(it.xr) * bpa_pkg::PROD_W'(it.wix)
          + bpa_pkg::PROD_W'(it.xi) * bpa_pkg::PROD_W'(it.wrx);
    pr_ry = bpa_pkg::PROD_W'(it.yr) * bpa_pkg::PROD_W'(it.wry)
          - bpa_pkg::PROD_W'(it.yi) * bpa_pkg::PROD_W'(it.wiy);
    pr_iy = bpa_pkg::PROD_W'(it.yr) * bpa_pkg::PROD_W'(it.wiy)
          + bpa_pkg::PROD_W'(it.yi) * bpa_pkg::PROD_W'(it.wry);
  end

  always_comb begin
    case (cnt_r[1:0])
      2'd0:    sq_sel = acc_rx_r;
      2'd1:    sq_sel = acc_ix_r;
      2'd2:    sq_sel = acc_ry_r;
      2'd3:    sq_sel = acc_iy_r;
      default: sq_sel = acc_rx_r;
    endcase
  end

  assign sq_full = sq_sel * sq_sel;
  assign pow     = sum_r[bpa_pkg::SUM_W-1:2*bpa_pkg::WEIGHT_FRAC_BITS];
  assign sat_lim = bpa_pkg::CMP_W'(denom) << bpa_pkg::QUO_W;
  assign trial   = bpa_pkg::CMP_W'(denom) << cnt_r;
  assign ge      = (rem_r >= trial);
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_MAC: begin
        if (q_pop && it.last) begin
          state_nxt = S_SQR;
        end
      end
      S_SQR: begin
        if (cnt_r == bpa_pkg::CNT_W'(bpa_pkg::NUM_ACC)) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        state_nxt = (bpa_pkg::CMP_W'(pow) >= sat_lim) ? S_OUT : S_DIV;
      end
      S_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_MAC;
        end
      end
      default: state_nxt = S_MAC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_MAC;
      acc_rx_r <= '0;
      acc_ix_r <= '0;
      acc_ry_r <= '0;
      acc_iy_r <= '0;
      cnt_r    <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_MAC: begin
          if (q_pop) begin
            acc_rx_r <= acc_rx_r + bpa_pkg::ACC_W'(pr_rx);
            acc_ix_r <= acc_ix_r + bpa_pkg::ACC_W'(pr_ix);
            acc_ry_r <= acc_ry_r + bpa_pkg::ACC_W'(pr_ry);
            acc_iy_r <= acc_iy_r + bpa_pkg::ACC_W'(pr_iy);
          end
          cnt_r <= '0;
        end
        S_SQR: begin
          if (cnt_r == bpa_pkg::CNT_W'(bpa_pkg::NUM_ACC)) begin
            acc_rx_r <= '0;
            acc_ix_r <= '0;
            acc_ry_r <= '0;
            acc_iy_r <= '0;
          end
          cnt_r <= cnt_r + bpa_pkg::CNT_W'(1);
        end
        S_LOAD: begin
          cnt_r <= bpa_pkg::CNT_W'(bpa_pkg::QUO_W - 1);
        end
        S_DIV: begin
          cnt_r <= cnt_r - bpa_pkg::CNT_W'(1);
        end
        S_OUT: begin
          cnt_r <= '0;
        end
        default: begin
          cnt_r <= '0;
        end
      endcase
    end
  end

  // squaring, divide datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_MAC: begin
        prod_r <= '0;
        sum_r  <= '0;
      end
      S_SQR: begin
        prod_r <= unsigned'(sq_full);
        sum_r  <= sum_r + bpa_pkg::SUM_W'(prod_r);
      end
      S_LOAD: begin
        rem_r <= bpa_pkg::CMP_W'(pow);
        sat_r <= (bpa_pkg::CMP_W'(pow) >= sat_lim);
        quo_r <= '0;
      end
      S_DIV: begin
        if (ge) begin
          rem_r <= rem_r - trial;
        end
        quo_r <= {quo_r[bpa_pkg::QUO_W-2:0], ge};
      end
      default: begin
        rem_r <= rem_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      power_r   <= sat_r ? {bpa_pkg::QUO_W{1'b1}} : quo_r;
      sat_out_r <= sat_r;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.beam_power      = power_r;
  assign out_ch.power_saturated = sat_out_r;

  a_last_to_sqr: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && it.last) |=> (state_r == S_SQR && cnt_r == '0))
    else $error("last request did not start power pass");

  a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SQR && cnt_r == bpa_pkg::CNT_W'(bpa_pkg::NUM_ACC)) |=>
      (acc_rx_r == '0 && acc_ix_r == '0 && acc_ry_r == '0 && acc_iy_r == '0))
    else $error("accumulators not cleared after power pass");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid_r && state_r == S_MAC))
    else $error("result not presented after load");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_MAC) |-> !q_pop)
    else $error("queue popped while power pass busy");

endmodule

/* tb/sv/beam_power_checker.sv */
`timescale 1ns / 1ps
module beam_power_checker (
  input  logic clk,
  input  logic rst_n,
  bpa_in_if    in_ch,
  bpa_cfg_if   cfg_ch,
  bpa_out_if   out_ch,
  output int   fail_count,
  output int   power_pending
);

  typedef struct packed {
    logic [bpa_pkg::QUO_W-1:0] beam_power;
    logic                      power_saturated;
  } beam_result_t;

  beam_result_t                     power_q[$];
  logic signed [bpa_pkg::ACC_W-1:0] acc_rx, acc_ix, acc_ry, acc_iy;
  logic [bpa_pkg::ANT_W-1:0]        ant_count;

  function automatic longint unsigned square_of(
    input logic signed [bpa_pkg::ACC_W-1:0] v);
    longint s;
    s = v;
    return s * s;
  endfunction

  always @(posedge clk) begin : track
    longint            xr, xi, yr, yi, wrx, wix, wry, wiy;
    longint unsigned   sq_sum, den, quo;
    beam_result_t      got, want;
    if (!rst_n) begin
      acc_rx = '0;
      acc_ix = '0;
      acc_ry = '0;
      acc_iy = '0;
      ant_count = bpa_pkg::ANT_W'(bpa_pkg::ANT_RESET);
      fail_count = 0;
      power_q.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        ant_count = cfg_ch.antennas_used;
        if (ant_count == 0) begin
          ant_count = 1;
        end else if (ant_count > bpa_pkg::MAX_ANTENNAS) begin
          ant_count = bpa_pkg::ANT_W'(bpa_pkg::MAX_ANTENNAS);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        xr  = longint'($signed(in_ch.sample_x[bpa_pkg::NIB_W-1:0]));
        xi  = longint'($signed(in_ch.sample_x[bpa_pkg::SMP_W-1:bpa_pkg::NIB_W]));
        yr  = longint'($signed(in_ch.sample_y[bpa_pkg::NIB_W-1:0]));
        yi  = longint'($signed(in_ch.sample_y[bpa_pkg::SMP_W-1:bpa_pkg::NIB_W]));
        wrx = longint'(in_ch.weight_re_x);
        wix = longint'(in_ch.weight_im_x);
        wry = longint'(in_ch.weight_re_y);
        wiy = longint'(in_ch.weight_im_y);
        acc_rx = bpa_pkg::ACC_W'(longint'(acc_rx) + xr * wrx - xi * wix);
        acc_ix = bpa_pkg::ACC_W'(longint'(acc_ix) + xr * wix + xi * wrx);
        acc_ry = bpa_pkg::ACC_W'(longint'(acc_ry) + yr * wry - yi * wiy);
        acc_iy = bpa_pkg::ACC_W'(longint'(acc_iy) + yr * wiy + yi * wry);
        if (in_ch.last_antenna) begin
          sq_sum = square_of(acc_rx) + square_of(acc_ix) + square_of(acc_ry)
                 + square_of(acc_iy);
          sq_sum = sq_sum >> (2 * bpa_pkg::WEIGHT_FRAC_BITS);
          den = ant_count * ant_count;
          quo = sq_sum / den;
          if (quo > 255) begin
            want.beam_power = '1;
            want.power_saturated = 1'b1;
          end else begin
            want.beam_power = quo[bpa_pkg::QUO_W-1:0];
            want.power_saturated = 1'b0;
          end
          power_q.push_back(want);
          acc_rx = '0;
          acc_ix = '0;
          acc_ry = '0;
          acc_iy = '0;
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        got.beam_power = out_ch.beam_power;
        got.power_saturated = out_ch.power_saturated;
        if (power_q.size() == 0) begin
          $error("unexpected beam result: beam_power %0d power_saturated %0b",
                 got.beam_power, got.power_saturated);
          fail_count++;
        end else begin
          want = power_q.pop_front();
          if (got.beam_power !== want.beam_power) begin
            $error("beam_power mismatch: expected %0d, actual %0d",
                   want.beam_power, got.beam_power);
            fail_count++;
          end
          if (got.power_saturated !== want.power_saturated) begin
            $error("power_saturated mismatch: expected %0b, actual %0b",
                   want.power_saturated, got.power_saturated);
            fail_count++;
          end
        end
      end
    end
    power_pending <= power_q.size();
  end

endmodule

/* tb/sv/beamformer_power_accumulator_core_tb.sv */
`timescale 1ns / 1ps
module beamformer_power_accumulator_core_tb;

  localparam int CYCLE_LIMIT  = 2000000;
  localparam int DRAIN_CYCLES = 30;
  localparam int LONG_HOLD    = 400;
  localparam int PHASE_ITEMS  = 110;
  localparam int NUM_PHASES   = 8;

  typedef enum {FRAME_NOISE, FRAME_COHERENT, FRAME_WRAP} frame_kind_t;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   power_pending;
  int   cycle_count = 0;
  int   items_sent = 0;
  int   hold_req = 0;
  int   hold_done = 0;
  int   stall_left = 0;
  bit   no_idle = 1'b0;

  bpa_in_if  in_ch ();
  bpa_cfg_if cfg_ch ();
  bpa_out_if out_ch ();

  beamformer_power_accumulator_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .out_ch (out_ch)
  );

  beam_power_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .cfg_ch        (cfg_ch),
    .out_ch        (out_ch),
    .fail_count    (fail_count),
    .power_pending (power_pending)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 19);
    if (no_idle || roll < 12) begin
      return 0;
    end else if (roll < 18) begin
      return $urandom_range(1, 3);
    end else if (roll < 19) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [bpa_pkg::WGT_W-1:0] rand_weight();
    case ($urandom_range(0, 3))
      0: begin
        return bpa_pkg::WGT_W'($urandom);
      end
      1: begin
        return bpa_pkg::WGT_W'(int'($urandom_range(0, 512)) - 256);
      end
      default: begin
        return bpa_pkg::WGT_W'(int'($urandom_range(0, 32768)) - 16384);
      end
    endcase
  endfunction

  // result side: random stalls plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_req != hold_done) begin
      hold_done = hold_req;
      stall_left = LONG_HOLD;
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  task automatic send_antenna(input logic [bpa_pkg::SMP_W-1:0] sx,
                              input logic [bpa_pkg::SMP_W-1:0] sy,
                              input logic [bpa_pkg::WGT_W-1:0] wrx,
                              input logic [bpa_pkg::WGT_W-1:0] wix,
                              input logic [bpa_pkg::WGT_W-1:0] wry,
                              input logic [bpa_pkg::WGT_W-1:0] wiy,
                              input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.sample_x     <= sx;
    in_ch.sample_y     <= sy;
    in_ch.weight_re_x  <= wrx;
    in_ch.weight_im_x  <= wix;
    in_ch.weight_re_y  <= wry;
    in_ch.weight_im_y  <= wiy;
    in_ch.last_antenna <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (power_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_antennas(input logic [bpa_pkg::ANT_W-1:0] v);
    wait_idle();
    cfg_ch.valid         <= 1'b1;
    cfg_ch.antennas_used <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_random_frame();
    int                        pick, len, k;
    frame_kind_t               kind;
    logic [bpa_pkg::SMP_W-1:0] sx, sy;
    logic [bpa_pkg::WGT_W-1:0] wrx, wix, wry, wiy;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      kind = FRAME_WRAP;
      len = $urandom_range(60, 130);
    end else if (pick < 25) begin
      kind = (pick < 15) ? FRAME_COHERENT : FRAME_NOISE;
      len = $urandom_range(7, 32);
    end else begin
      kind = pick[0] ? FRAME_COHERENT : FRAME_NOISE;
      len = $urandom_range(1, 6);
    end
    sx = bpa_pkg::SMP_W'($urandom);
    sy = bpa_pkg::SMP_W'($urandom);
    wrx = rand_weight();
    wix = rand_weight();
    wry = rand_weight();
    wiy = rand_weight();
    for (k = 0; k < len; k++) begin
      if (kind == FRAME_NOISE) begin
        sx = bpa_pkg::SMP_W'($urandom);
        sy = bpa_pkg::SMP_W'($urandom);
        wrx = rand_weight();
        wix = rand_weight();
        wry = rand_weight();
        wiy = rand_weight();
      end else if (kind == FRAME_WRAP) begin
        // near-extreme same-sign terms so the sums run past the accumulator width
        sx = ($urandom_range(0, 3) == 0) ? bpa_pkg::SMP_W'($urandom) : 8'h88;
        sy = ($urandom_range(0, 3) == 0) ? bpa_pkg::SMP_W'($urandom) : 8'h88;
        wrx = 16'h8000;
        wix = 16'h7fff;
        wry = 16'h8000;
        wiy = 16'h7fff;
      end
      send_antenna(sx, sy, wrx, wix, wry, wiy, k == len - 1);
    end
  endtask

  initial begin
    int phase;
    int budget;
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.sample_x       = '0;
    in_ch.sample_y       = '0;
    in_ch.weight_re_x    = '0;
    in_ch.weight_im_x    = '0;
    in_ch.weight_re_y    = '0;
    in_ch.weight_im_y    = '0;
    in_ch.last_antenna   = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.antennas_used = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset antenna count
    send_antenna(8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
    send_antenna(8'h77, 8'h77, 16'h4000, 16'h4000, 16'h4000, 16'h4000, 1'b1);
    send_antenna(8'h88, 8'h88, 16'hc000, 16'hc000, 16'hc000, 16'hc000, 1'b1);
    send_antenna(8'h88, 8'h88, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 1'b1);
    send_antenna(8'h78, 8'h87, 16'h7fff, 16'h8000, 16'h0001, 16'hffff, 1'b1);
    send_antenna(8'h07, 8'h70, 16'h4000, 16'h0000, 16'h0000, 16'h4000, 1'b1);
    send_antenna(8'h0f, 8'hf0, 16'h2000, 16'he000, 16'h1234, 16'hedcc, 1'b0);
    send_antenna(8'hf0, 8'h0f, 16'hc000, 16'h4000, 16'h0100, 16'hff00, 1'b0);
    send_antenna(8'h80, 8'h08, 16'h3fff, 16'hc001, 16'h7fff, 16'h8000, 1'b0);
    send_antenna(8'h08, 8'h80, 16'h4000, 16'h4000, 16'hc000, 16'hc000, 1'b1);
    send_antenna(8'hff, 8'h11, 16'h0001, 16'hffff, 16'h0400, 16'hfc00, 1'b1);

    // antenna count written as zero
    write_antennas(7'd0);
    send_antenna(8'h11, 8'h00, 16'h4000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
    send_antenna(8'h77, 8'h77, 16'h4000, 16'h4000, 16'h4000, 16'h4000, 1'b1);
    send_antenna(8'h01, 8'h10, 16'h2000, 16'h0000, 16'h0000, 16'h2000, 1'b1);

    // above the maximum count
    write_antennas(7'd127);
    send_antenna(8'h88, 8'h88, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 1'b0);
    send_antenna(8'h88, 8'h88, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 1'b1);
    send_antenna(8'h77, 8'h88, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 1'b1);

    write_antennas(7'd1);
    send_antenna(8'h12, 8'h21, 16'h0800, 16'hf800, 16'h0800, 16'h0800, 1'b1);
    send_antenna(8'h99, 8'h66, 16'h1000, 16'h1000, 16'hf000, 16'h1000, 1'b1);

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        1: begin
          write_antennas(7'd64);
        end
        2: begin
          write_antennas(7'd0);
        end
        3: begin
          write_antennas(7'd65);
        end
        4: begin
          write_antennas(7'd1);
        end
        5: begin
          write_antennas(bpa_pkg::ANT_W'($urandom_range(2, 63)));
        end
        6: begin
          write_antennas(bpa_pkg::ANT_W'($urandom_range(0, 127)));
        end
        7: begin
          write_antennas(7'd127);
        end
        default: begin
          write_antennas(7'd24);
        end
      endcase
      no_idle <= (phase == 4);
      if (phase == 2) begin
        hold_req <= hold_req + 1;
      end
      budget = items_sent + PHASE_ITEMS;
      while (items_sent < budget) send_random_frame();
    end

    wait_idle();
    if (fail_count == 0 && power_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
